[hw/rtl/sbl_pkg.sv]
// shared types and constants of the serial boot loader command engine
// used by sbl_front, sbl_queue, sbl_back and the top level; no dependencies
package sbl_pkg;

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 8;
    localparam int RUN_W       = 32;
    localparam int WADDR_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_ACK        = 3'd0;
    localparam logic [2:0] REG_NAK        = 3'd1;
    localparam logic [2:0] REG_PING       = 3'd2;
    localparam logic [2:0] REG_DOWNLOAD   = 3'd3;
    localparam logic [2:0] REG_RUN        = 3'd4;
    localparam logic [2:0] REG_GET_STATUS = 3'd5;
    localparam logic [2:0] REG_SEND_DATA  = 3'd6;
    localparam logic [2:0] REG_RESET      = 3'd7;

    // decoded commands
    localparam logic [2:0] OP_PING     = 3'd0;
    localparam logic [2:0] OP_STATUS   = 3'd1;
    localparam logic [2:0] OP_DOWNLOAD = 3'd2;
    localparam logic [2:0] OP_SEND     = 3'd3;
    localparam logic [2:0] OP_RUN      = 3'd4;
    localparam logic [2:0] OP_RESET    = 3'd5;
    localparam logic [2:0] OP_UNKNOWN  = 3'd6;

    localparam logic [BYTE_W-1:0] MIN_LEN     = 8'h03;
    localparam logic [BYTE_W-1:0] STATUS_LEN  = 8'h03;
    localparam logic [BYTE_W-1:0] STATUS_DONE = 8'h40;
    localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

    // one queue entry: a data byte of a frame, the end of a frame, or both
    typedef struct packed {
        logic              has_data;
        logic              is_end;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  length;
        logic [BYTE_W-1:0] cmd;
        logic [RUN_W-1:0]  run_addr;
    } job_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ack;
        logic [BYTE_W-1:0] nak;
        logic [BYTE_W-1:0] ping;
        logic [BYTE_W-1:0] download;
        logic [BYTE_W-1:0] run;
        logic [BYTE_W-1:0] get_status;
        logic [BYTE_W-1:0] send_data;
        logic [BYTE_W-1:0] rst;
    } cfg_t;

endpackage

[hw/rtl/sbl_queue.sv]
// short job queue between the frame collector and the command sequencer
// depends on sbl_pkg for the entry type and depth
module sbl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sbl_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output sbl_pkg::job_t pop_data,
    output logic          empty
);
    import sbl_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full     = (count_reg == (PW + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hw/rtl/sbl_front.sv]
// frame collector: takes received bytes, checks the length byte, tracks the frame
// and queues data bytes and frame ends; depends on sbl_pkg
module sbl_front #(
    parameter int PACKET_MAX = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rx_valid,
    output logic                      rx_ready,
    input  logic [sbl_pkg::BYTE_W-1:0] rx_byte,
    output logic                      push,
    output sbl_pkg::job_t             push_data,
    input  logic                      full
);
    import sbl_pkg::*;

    logic              collecting_reg;
    logic [IDX_W-1:0]  len_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] cmd_next;
    logic [RUN_W-1:0]  ra_reg;
    logic [RUN_W-1:0]  ra_next;
    logic [IDX_W-1:0]  cnt_inc;
    logic              accept;
    logic              len_ok;
    logic              frame_end;

    assign rx_ready  = !full;
    assign accept    = rx_valid && rx_ready;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign len_ok    = (rx_byte >= MIN_LEN) && (rx_byte <= BYTE_W'(PACKET_MAX));
    assign frame_end = (cnt_inc == len_reg);

    always_comb
    begin
        cmd_next = cmd_reg;
        ra_next  = ra_reg;
        case (cnt_reg)
            8'd2:    cmd_next        = rx_byte;
            8'd3:    ra_next[31:24]  = rx_byte;
            8'd4:    ra_next[23:16]  = rx_byte;
            8'd5:    ra_next[15:8]   = rx_byte;
            8'd6:    ra_next[7:0]    = rx_byte;
            default: ra_next         = ra_reg;
        endcase
    end

    // bytes from index 3 on are payload; the final byte also closes the frame
    assign push = accept && collecting_reg && ((cnt_reg >= MIN_LEN) || frame_end);

    always_comb
    begin
        push_data.has_data = (cnt_reg >= MIN_LEN);
        push_data.is_end   = frame_end;
        push_data.data     = rx_byte;
        push_data.idx      = cnt_reg;
        push_data.length   = len_reg;
        push_data.cmd      = cmd_next;
        push_data.run_addr = ra_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            len_reg        <= '0;
            cnt_reg        <= '0;
            cmd_reg        <= '0;
            ra_reg         <= '0;
        end
        else if (accept)
        begin
            if (!collecting_reg)
            begin
                if (len_ok)
                begin
                    collecting_reg <= 1'b1;
                    len_reg        <= rx_byte;
                    cnt_reg        <= 8'd1;
                    cmd_reg        <= '0;
                    ra_reg         <= '0;
                end
            end
            else
            begin
                cmd_reg <= cmd_next;
                ra_reg  <= ra_next;
                if (frame_end)
                begin
                    collecting_reg <= 1'b0;
                    cnt_reg        <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_inc;
                end
            end
        end
    end

endmodule

[hw/rtl/sbl_back.sv]
// command sequencer: drains the job queue, holds the frame payload memory,
// runs each completed frame and drives the result register; depends on sbl_pkg
module sbl_back #(
    parameter int PACKET_MAX = 15,
    parameter int ADDR_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbl_pkg::cfg_t               cfg,
    input  logic                        q_empty,
    input  sbl_pkg::job_t               q_data,
    output logic                        q_pop,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic                        kind,
    output logic [sbl_pkg::BYTE_W-1:0]  byte_value,
    output logic [sbl_pkg::WADDR_W-1:0] write_address,
    output logic                        start_run,
    output logic [sbl_pkg::RUN_W-1:0]   run_address,
    output logic                        last
);
    import sbl_pkg::*;

    localparam int AW = (PACKET_MAX > 1) ? $clog2(PACKET_MAX) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_WRITE  = 3'd2;
    localparam logic [2:0] ST_ACK    = 3'd3;
    localparam logic [2:0] ST_STATUS = 3'd4;
    localparam logic [2:0] ST_ZERO   = 3'd5;

    logic [BYTE_W-1:0]    mem [PACKET_MAX];
    logic [BYTE_W-1:0]    mem_q_reg;

    logic [2:0]           state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [IDX_W-1:0]     len_reg, len_next;
    logic [RUN_W-1:0]     ra_reg, ra_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [1:0]           step_reg, step_next;
    logic [ADDR_BITS-1:0] ptr_reg, ptr_next;
    logic                 status_seen_reg, status_seen_next;
    logic                 finished_reg, finished_next;

    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic [WADDR_W-1:0]   out_waddr_reg;
    logic                 out_start_run_reg;
    logic [RUN_W-1:0]     out_raddr_reg;
    logic                 out_last_reg;

    logic                 emit;
    logic                 e_kind;
    logic [BYTE_W-1:0]    e_byte;
    logic [WADDR_W-1:0]   e_waddr;
    logic                 e_start_run;
    logic [RUN_W-1:0]     e_raddr;
    logic                 e_last;

    logic                 can_emit;
    logic [2:0]           dec_op;
    logic [31:0]          ptr_ext;
    logic [BYTE_W-1:0]    st_byte;

    assign can_emit = !out_valid_reg || res_ready;
    assign ptr_ext  = 32'(ptr_reg);
    assign st_byte  = status_seen_reg ? STATUS_DONE : ZERO_BYTE;

    // first match wins when codes coincide
    always_comb
    begin
        if (q_data.cmd == cfg.ping)
            dec_op = OP_PING;
        else if (q_data.cmd == cfg.get_status)
            dec_op = OP_STATUS;
        else if (q_data.cmd == cfg.download)
            dec_op = OP_DOWNLOAD;
        else if (q_data.cmd == cfg.send_data)
            dec_op = OP_SEND;
        else if (q_data.cmd == cfg.run)
            dec_op = OP_RUN;
        else if (q_data.cmd == cfg.rst)
            dec_op = OP_RESET;
        else
            dec_op = OP_UNKNOWN;
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        len_next         = len_reg;
        ra_next          = ra_reg;
        rd_idx_next      = rd_idx_reg;
        step_next        = step_reg;
        ptr_next         = ptr_reg;
        status_seen_next = status_seen_reg;
        finished_next    = finished_reg;
        q_pop            = 1'b0;
        emit             = 1'b0;
        e_kind           = 1'b0;
        e_byte           = ZERO_BYTE;
        e_waddr          = '0;
        e_start_run      = 1'b0;
        e_raddr          = '0;
        e_last           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    // once finished, entries are drained and dropped
                    if (!finished_reg && q_data.is_end)
                    begin
                        len_next = q_data.length;
                        ra_next  = q_data.run_addr;
                        op_next  = dec_op;
                        if (dec_op == OP_RESET)
                        begin
                            ptr_next         = '0;
                            status_seen_next = 1'b1;
                        end
                        else if (dec_op == OP_SEND && q_data.length > MIN_LEN)
                        begin
                            rd_idx_next = MIN_LEN;
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_ACK;
                        end
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    e_kind      = 1'b1;
                    e_byte      = mem_q_reg;
                    e_waddr     = ptr_ext[WADDR_W-1:0];
                    ptr_next    = ptr_reg + ADDR_BITS'(1);
                    rd_idx_next = rd_idx_reg + 1'b1;
                    state_next  = (rd_idx_next < len_reg) ? ST_READ : ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    e_byte     = (op_reg == OP_UNKNOWN) ? cfg.nak : cfg.ack;
                    step_next  = '0;
                    state_next = (op_reg == OP_STATUS) ? ST_STATUS : ST_ZERO;
                end
            end
            ST_STATUS:
            begin
                if (can_emit)
                begin
                    emit      = 1'b1;
                    e_byte    = (step_reg == 2'd0) ? STATUS_LEN : st_byte;
                    step_next = step_reg + 1'b1;
                    if (step_reg == 2'd2)
                    begin
                        state_next = ST_ZERO;
                    end
                end
            end
            ST_ZERO:
            begin
                if (can_emit)
                begin
                    emit             = 1'b1;
                    e_last           = 1'b1;
                    e_start_run      = (op_reg == OP_RUN);
                    e_raddr          = (op_reg == OP_RUN) ? ra_reg : '0;
                    status_seen_next = 1'b1;
                    if (op_reg == OP_RUN)
                    begin
                        finished_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // payload memory, one write port from the queue and one registered read port
    always_ff @(posedge clk)
    begin
        if (q_pop && !q_empty && !finished_reg && q_data.has_data)
        begin
            mem[q_data.idx[AW-1:0]] <= q_data.data;
        end
        mem_q_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_UNKNOWN;
            len_reg         <= '0;
            ra_reg          <= '0;
            rd_idx_reg      <= '0;
            step_reg        <= '0;
            ptr_reg         <= '0;
            status_seen_reg <= 1'b0;
            finished_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            len_reg         <= len_next;
            ra_reg          <= ra_next;
            rd_idx_reg      <= rd_idx_next;
            step_reg        <= step_next;
            ptr_reg         <= ptr_next;
            status_seen_reg <= status_seen_next;
            finished_reg    <= finished_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg      <= e_kind;
            out_byte_reg      <= e_byte;
            out_waddr_reg     <= e_waddr;
            out_start_run_reg <= e_start_run;
            out_raddr_reg     <= e_raddr;
            out_last_reg      <= e_last;
        end
    end

    assign res_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign byte_value    = out_byte_reg;
    assign write_address = out_waddr_reg;
    assign start_run     = out_start_run_reg;
    assign run_address   = out_raddr_reg;
    assign last          = out_last_reg;

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("loader left the finished state");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> (rd_idx_reg >= MIN_LEN && rd_idx_reg < len_reg))
        else $error("payload read outside the frame");

    a_run_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_start_run_reg) |-> (out_last_reg && !out_kind_reg))
        else $error("start_run on a result that does not close the frame");

    a_write_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg) |-> !out_last_reg)
        else $error("memory write flagged as last result");

endmodule

[hw/rtl/serial_boot_loader_command_engine_unit.sv]
// serial boot loader command engine: configuration registers and the
// frame collector, job queue and command sequencer; depends on sbl_pkg
//
// usage:
//   rx channel (rx_valid/rx_ready/rx_byte) takes one received byte per beat.
//   a frame is a length byte N (3..PACKET_MAX), a checksum byte that is not
//   checked, a command byte and N-3 payload bytes.
//   res channel (res_valid/res_ready) carries result beats: transmit bytes
//   (kind 0) and program memory writes (kind 1); last marks the final beat of
//   a frame and start_run/run_address come on the final beat of a run frame.
//   the collector takes a byte every cycle while the two-entry job queue has
//   room; once the last byte of a frame has passed the queue and the idle
//   sequencer, its results leave through the result register, one transmit
//   beat per cycle while res_ready is high, and each write beat of send data
//   goes through a read and a write state (payload memory read port).
//   when res_ready is low the result register holds; the queue fills and then
//   rx_ready drops, so no byte is lost.
//   reset clears the frame state, write pointer, status and finished flag and
//   loads the default codes; no clearing pass is needed.
//   the user must write the APB port only while the engine is idle; the block does not enforce this.
module serial_boot_loader_command_engine_unit #(
    parameter int PACKET_MAX = 15,
    parameter int ADDR_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rx_valid,
    output logic                            rx_ready,
    input  logic [sbl_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic                            kind,
    output logic [sbl_pkg::BYTE_W-1:0]      byte_value,
    output logic [sbl_pkg::WADDR_W-1:0]     write_address,
    output logic                            start_run,
    output logic [sbl_pkg::RUN_W-1:0]       run_address,
    output logic                            last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sbl_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sbl_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [sbl_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sbl_pkg::*;

    cfg_t              cfg_reg;
    logic [2:0]        reg_idx;
    logic [BYTE_W-1:0] rd_sel;
    logic              cfg_write;

    job_t              push_data;
    job_t              pop_data;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack        <= 8'd204;
            cfg_reg.nak        <= 8'd51;
            cfg_reg.ping       <= 8'd32;
            cfg_reg.download   <= 8'd33;
            cfg_reg.run        <= 8'd34;
            cfg_reg.get_status <= 8'd35;
            cfg_reg.send_data  <= 8'd36;
            cfg_reg.rst        <= 8'd37;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_ACK:        cfg_reg.ack        <= pwdata[BYTE_W-1:0];
                REG_NAK:        cfg_reg.nak        <= pwdata[BYTE_W-1:0];
                REG_PING:       cfg_reg.ping       <= pwdata[BYTE_W-1:0];
                REG_DOWNLOAD:   cfg_reg.download   <= pwdata[BYTE_W-1:0];
                REG_RUN:        cfg_reg.run        <= pwdata[BYTE_W-1:0];
                REG_GET_STATUS: cfg_reg.get_status <= pwdata[BYTE_W-1:0];
                REG_SEND_DATA:  cfg_reg.send_data  <= pwdata[BYTE_W-1:0];
                REG_RESET:      cfg_reg.rst        <= pwdata[BYTE_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ACK:        rd_sel = cfg_reg.ack;
            REG_NAK:        rd_sel = cfg_reg.nak;
            REG_PING:       rd_sel = cfg_reg.ping;
            REG_DOWNLOAD:   rd_sel = cfg_reg.download;
            REG_RUN:        rd_sel = cfg_reg.run;
            REG_GET_STATUS: rd_sel = cfg_reg.get_status;
            REG_SEND_DATA:  rd_sel = cfg_reg.send_data;
            REG_RESET:      rd_sel = cfg_reg.rst;
            default:        rd_sel = '0;
        endcase
    end

    assign prdata = CFG_DATA_W'(rd_sel);

    sbl_front #(
        .PACKET_MAX (PACKET_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    sbl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sbl_back #(
        .PACKET_MAX (PACKET_MAX),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (empty),
        .q_data        (pop_data),
        .q_pop         (pop),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .kind          (kind),
        .byte_value    (byte_value),
        .write_address (write_address),
        .start_run     (start_run),
        .run_address   (run_address),
        .last          (last)
    );

endmodule
